// ----- hw/rtl/rcfd_pkg.sv -----
`timescale 1ns / 1ps

package rcfd_pkg;

   // Frame geometry
   localparam int FRAME_BYTES  = 18;
   localparam int BUFFER_BYTES = 36;
   localparam int COUNT_W      = 6;
   localparam int INDEX_W      = 5;
   localparam int CHAN_W       = 11;

   // Centring and Q1.14 scaling by 16384/660
   localparam int CENTRE       = 1024;
   localparam int LANES        = 5;
   localparam int VAL_W        = 18;
   localparam int MAG_W        = 16;
   localparam int NUM_W        = 28;
   localparam int RECIP_W      = 29;
   localparam int PROD_W       = NUM_W + RECIP_W;
   localparam int RECIP_SHIFT  = 36;
   localparam int Q_W          = 20;
   localparam int RES_W        = 16;

   // mag*16384 + 330 over 660 equals (mag*4096 + 82) over 165, floored
   localparam logic [NUM_W-1:0]   ROUND_BIAS = 28'd82;
   // ceil(2^36 / 165)
   localparam logic [RECIP_W-1:0] RECIP_165  = 29'd416481678;

   // Lane order
   localparam int LANE_RIGHT_X = 0;
   localparam int LANE_RIGHT_Y = 1;
   localparam int LANE_LEFT_X  = 2;
   localparam int LANE_LEFT_Y  = 3;
   localparam int LANE_WHEEL   = 4;

   // Input command codes
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_IDLE = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } rcfd_req_type;

   typedef struct packed {
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic        [1:0]  switch_one;
      logic        [1:0]  switch_two;
      logic signed [15:0] mouse_x;
      logic signed [15:0] mouse_y;
      logic signed [15:0] mouse_z;
      logic        [15:0] mouse_buttons;
      logic        [15:0] key_mask;
      logic signed [15:0] wheel;
   } rcfd_rsp_type;

   // Fields that pass through without scaling
   typedef struct packed {
      logic [1:0]  switch_one;
      logic [1:0]  switch_two;
      logic [15:0] mouse_x;
      logic [15:0] mouse_y;
      logic [15:0] mouse_z;
      logic [15:0] mouse_buttons;
      logic [15:0] key_mask;
   } rcfd_side_type;

   // One captured frame, centred, split into sign and magnitude
   typedef struct packed {
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][MAG_W-1:0] mag;
      rcfd_side_type               side;
   } rcfd_frame_type;

endpackage

// ----- hw/rtl/remote_control_frame_decoder_unit.sv -----
// A frame's result is built once its idle beat is taken: the capture register loads
// on that beat, then the multiply register, then the result register.
// Throughput: one request beat per cycle unless capture holds a frame; the three stages
// drain independently: a stalled result never blocks data bytes while capture is free.
// Reset (synchronous, active high) clears the byte count and all valid flags.
`timescale 1ns / 1ps

module remote_control_frame_decoder_unit
   import rcfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  rcfd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rcfd_rsp_type rsp_data
);

   logic           frame_valid;
   logic           frame_ready;
   rcfd_frame_type frame_data;

   rcfd_frame_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame_data  (frame_data)
   );

   rcfd_decode_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame_data  (frame_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

`ifndef SYNTHESIS
   // A data byte never launches a frame
   a_data_no_frame: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.cmd == CMD_DATA)) |=> !frame_valid)
      else $error("frame launched by a data beat");

   // An empty capture register always takes the next beat
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !frame_valid |-> req_ready)
      else $error("request stalled with empty capture stage");

   // A new result comes from a frame handed on through the mid stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(frame_valid && frame_ready, 2))
      else $error("result without a frame two cycles before");
`endif

endmodule

// ----- hw/rtl/rcfd_frame_capture.sv -----
`timescale 1ns / 1ps

module rcfd_frame_capture
   import rcfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rcfd_req_type   req_data,
   output logic           frame_valid,
   input  logic           frame_ready,
   output rcfd_frame_type frame_data
);

   logic [7:0]         store_ff [FRAME_BYTES];
   logic [7:0]         store_in [FRAME_BYTES];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               frame_valid_ff;
   logic               frame_valid_in;
   rcfd_frame_type     frame_ff;
   rcfd_frame_type     frame_in;

   logic req_fire;
   logic is_data;
   logic frame_full;
   logic take_frame;

   logic [3:0][CHAN_W-1:0]      chan;
   logic [15:0]                 wheel_raw;
   logic signed [VAL_W-1:0]     cent [LANES];
   logic [VAL_W-1:0]            absv [LANES];

   assign req_ready  = !frame_valid_ff || frame_ready;
   assign req_fire   = req_valid && req_ready;
   assign is_data    = (req_data.cmd == CMD_DATA);
   assign frame_full = (count_ff == COUNT_W'(FRAME_BYTES));
   assign take_frame = req_fire && !is_data && frame_full;

   // Byte count: saturating on data, cleared on idle
   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         if (is_data) begin
            if (count_ff < COUNT_W'(BUFFER_BYTES)) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else begin
            count_in = '0;
         end
      end
   end

   // Frame store: only the first FRAME_BYTES bytes of a burst land
   always_comb begin
      store_in = store_ff;
      if (req_fire && is_data && (count_ff < COUNT_W'(FRAME_BYTES))) begin
         store_in[count_ff[INDEX_W-1:0]] = req_data.rx_byte;
      end
   end

   // Unpack the 11-bit stick channels and the wheel word
   assign chan[0]   = {store_ff[1][2:0], store_ff[0]};
   assign chan[1]   = {store_ff[2][5:0], store_ff[1][7:3]};
   assign chan[2]   = {store_ff[4][0], store_ff[3], store_ff[2][7:6]};
   assign chan[3]   = {store_ff[5][3:0], store_ff[4][7:1]};
   assign wheel_raw = {store_ff[17], store_ff[16]};

   // Centre and split into sign and magnitude
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cent[i] = $signed({{(VAL_W-CHAN_W){1'b0}}, chan[i]}) - $signed(VAL_W'(CENTRE));
      end
      cent[LANE_WHEEL] = $signed({{(VAL_W-16){wheel_raw[15]}}, wheel_raw})
                         - $signed(VAL_W'(CENTRE));
      for (int i = 0; i < LANES; i++) begin
         absv[i] = cent[i][VAL_W-1] ? VAL_W'(-cent[i]) : VAL_W'(cent[i]);
      end
   end

   // Frame output register
   always_comb begin
      frame_in = frame_ff;
      if (take_frame) begin
         for (int i = 0; i < LANES; i++) begin
            frame_in.neg[i] = cent[i][VAL_W-1];
            frame_in.mag[i] = absv[i][MAG_W-1:0];
         end
         frame_in.side.switch_one    = store_ff[5][7:6];
         frame_in.side.switch_two    = store_ff[5][5:4];
         frame_in.side.mouse_x       = {store_ff[7], store_ff[6]};
         frame_in.side.mouse_y       = {store_ff[9], store_ff[8]};
         frame_in.side.mouse_z       = {store_ff[11], store_ff[10]};
         frame_in.side.mouse_buttons = {store_ff[13], store_ff[12]};
         frame_in.side.key_mask      = {store_ff[15], store_ff[14]};
      end
   end

   assign frame_valid_in = req_fire ? take_frame : (frame_valid_ff && !frame_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         count_ff       <= count_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      frame_ff <= frame_in;
   end

   assign frame_valid = frame_valid_ff;
   assign frame_data  = frame_ff;

endmodule

// ----- hw/rtl/rcfd_scale_lane.sv -----
`timescale 1ns / 1ps

module rcfd_scale_lane
   import rcfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    load,
   input  logic [MAG_W-1:0]        mag_in,
   input  logic                    neg_in,
   output logic signed [RES_W-1:0] result
);

   localparam logic signed [Q_W:0] SAT_MAX = (Q_W+1)'(32767);
   localparam logic signed [Q_W:0] SAT_MIN = -(Q_W+1)'(32768);

   logic [Q_W-1:0]   q_ff;
   logic [Q_W-1:0]   q_in;
   logic             neg_ff;
   logic             neg_in_r;
   logic [NUM_W-1:0] num;
   logic [PROD_W-1:0] prod;
   logic signed [Q_W:0] sq;

   // Rounded numerator, then divide by 165 via reciprocal multiply
   assign num  = {mag_in, {(NUM_W-MAG_W){1'b0}}} + ROUND_BIAS;
   assign prod = PROD_W'(num) * PROD_W'(RECIP_165);
   assign q_in = prod[RECIP_SHIFT +: Q_W];
   assign neg_in_r = load ? neg_in : neg_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         q_ff <= q_in;
      end
      neg_ff <= neg_in_r;
   end

   // Restore sign and saturate to 16 bits
   always_comb begin
      sq = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      priority if (sq > SAT_MAX) begin
         result = SAT_MAX[RES_W-1:0];
      end else if (sq < SAT_MIN) begin
         result = SAT_MIN[RES_W-1:0];
      end else begin
         result = sq[RES_W-1:0];
      end
   end

endmodule

// ----- hw/rtl/rcfd_decode_pipe.sv -----
`timescale 1ns / 1ps

module rcfd_decode_pipe
   import rcfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           frame_valid,
   output logic           frame_ready,
   input  rcfd_frame_type frame_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rcfd_rsp_type   rsp_data
);

   logic          mid_valid_ff;
   logic          mid_valid_in;
   rcfd_side_type mid_side_ff;
   rcfd_side_type mid_side_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rcfd_rsp_type  rsp_ff;
   rcfd_rsp_type  rsp_in;

   logic out_open;
   logic mid_open;
   logic mid_load;
   logic rsp_load;
   logic signed [LANES-1:0][RES_W-1:0] lane_res;

   // Each stage takes a beat when it is empty or draining
   assign out_open    = !rsp_valid_ff || rsp_ready;
   assign mid_open    = !mid_valid_ff || out_open;
   assign mid_load    = mid_open && frame_valid;
   assign rsp_load    = out_open && mid_valid_ff;
   assign frame_ready = mid_open;

   assign mid_valid_in = mid_open ? frame_valid : mid_valid_ff;
   assign rsp_valid_in = out_open ? mid_valid_ff : rsp_valid_ff;
   assign mid_side_in  = mid_load ? frame_data.side : mid_side_ff;

   // Scaling lanes: multiply into the mid stage, finish into the result
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      rcfd_scale_lane u_lane (
         .clock  (clock),
         .load   (mid_load),
         .mag_in (frame_data.mag[i]),
         .neg_in (frame_data.neg[i]),
         .result (lane_res[i])
      );
   end

   // Result assembly
   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in.right_x       = lane_res[LANE_RIGHT_X];
         rsp_in.right_y       = lane_res[LANE_RIGHT_Y];
         rsp_in.left_x        = lane_res[LANE_LEFT_X];
         rsp_in.left_y        = lane_res[LANE_LEFT_Y];
         rsp_in.switch_one    = mid_side_ff.switch_one;
         rsp_in.switch_two    = mid_side_ff.switch_two;
         rsp_in.mouse_x       = mid_side_ff.mouse_x;
         rsp_in.mouse_y       = mid_side_ff.mouse_y;
         rsp_in.mouse_z       = mid_side_ff.mouse_z;
         rsp_in.mouse_buttons = mid_side_ff.mouse_buttons;
         rsp_in.key_mask      = mid_side_ff.key_mask;
         rsp_in.wheel         = lane_res[LANE_WHEEL];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_side_ff <= mid_side_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sim/tb_remote_control_frame_decoder_unit.sv -----
`timescale 1ns / 1ps

module tb_remote_control_frame_decoder_unit;
   import rcfd_pkg::*;

   localparam int SCALE_DIV   = 660;
   localparam int Q_ONE       = 16384;
   localparam int FRAME_W     = FRAME_BYTES * 8;
   localparam int RANDOM_BEATS = 1100;
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 30;
   localparam int LONG_HOLD   = 600;

   // Frame predictor plus store of expected decoded frames
   class frame_checker;
      logic [7:0]   stored [FRAME_BYTES];
      int           burst_len;
      rcfd_rsp_type pending_frames[$];
      int           errors;
      int           frames_checked;

      function new();
         foreach (stored[k]) stored[k] = 8'h00;
         burst_len      = 0;
         errors         = 0;
         frames_checked = 0;
      endfunction

      // v * 16384 / 660, nearest, ties away from zero
      function int scale_to_q14(int v);
         longint mag;
         longint q;
         mag = (v < 0) ? -v : v;
         q = (mag * Q_ONE + SCALE_DIV / 2) / SCALE_DIV;
         return (v < 0) ? int'(-q) : int'(q);
      endfunction

      function int clip_s16(int v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function rcfd_rsp_type decode();
         rcfd_rsp_type f;
         logic [47:0]  sticks;
         logic [15:0]  raw_wheel;
         sticks = {stored[5], stored[4], stored[3], stored[2], stored[1], stored[0]};
         f.right_x = 16'(scale_to_q14(int'(sticks[10:0]) - CENTRE));
         f.right_y = 16'(scale_to_q14(int'(sticks[21:11]) - CENTRE));
         f.left_x  = 16'(scale_to_q14(int'(sticks[32:22]) - CENTRE));
         f.left_y  = 16'(scale_to_q14(int'(sticks[43:33]) - CENTRE));
         f.switch_one    = stored[5][7:6];
         f.switch_two    = stored[5][5:4];
         f.mouse_x       = {stored[7], stored[6]};
         f.mouse_y       = {stored[9], stored[8]};
         f.mouse_z       = {stored[11], stored[10]};
         f.mouse_buttons = {stored[13], stored[12]};
         f.key_mask      = {stored[15], stored[14]};
         raw_wheel = {stored[17], stored[16]};
         f.wheel = 16'(clip_s16(scale_to_q14(int'($signed(raw_wheel)) - CENTRE)));
         return f;
      endfunction

      // Accepted request beat: store/count bytes, decode on idle
      function void take_beat(rcfd_req_type beat);
         if (beat.cmd == CMD_DATA) begin
            if (burst_len < FRAME_BYTES) stored[burst_len] = beat.rx_byte;
            if (burst_len < BUFFER_BYTES) burst_len++;
         end else begin
            if (burst_len == FRAME_BYTES) pending_frames.push_back(decode());
            burst_len = 0;
         end
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got)
            note_error($sformatf("frame %0d %s: expected %0d, got %0d",
                                 frames_checked, name, want, got));
      endfunction

      // Accepted result beat against the oldest expected frame
      function void compare_frame(rcfd_rsp_type got);
         rcfd_rsp_type want;
         if (pending_frames.size() == 0) begin
            note_error("result beat with no frame expected");
            return;
         end
         want = pending_frames.pop_front();
         check_field("right_x", int'(want.right_x), int'(got.right_x));
         check_field("right_y", int'(want.right_y), int'(got.right_y));
         check_field("left_x", int'(want.left_x), int'(got.left_x));
         check_field("left_y", int'(want.left_y), int'(got.left_y));
         check_field("switch_one", int'(want.switch_one), int'(got.switch_one));
         check_field("switch_two", int'(want.switch_two), int'(got.switch_two));
         check_field("mouse_x", int'(want.mouse_x), int'(got.mouse_x));
         check_field("mouse_y", int'(want.mouse_y), int'(got.mouse_y));
         check_field("mouse_z", int'(want.mouse_z), int'(got.mouse_z));
         check_field("mouse_buttons", int'(want.mouse_buttons), int'(got.mouse_buttons));
         check_field("key_mask", int'(want.key_mask), int'(got.key_mask));
         check_field("wheel", int'(want.wheel), int'(got.wheel));
         frames_checked++;
      endfunction

      function int pending_count();
         return pending_frames.size();
      endfunction

      function int error_count();
         return errors + pending_frames.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   rcfd_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rcfd_rsp_type rsp_data;

   frame_checker frames;
   int           quiet_cycles = 0;
   int           burst_left = 0;

   remote_control_frame_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Reset once at start
   initial begin
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) frames.take_beat(req_data);
         if (rsp_valid && rsp_ready) frames.compare_frame(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: too long without any beat
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offer one request beat, with bursts and gaps, and wait for acceptance
   task automatic send_beat(input logic cmd, input logic [7:0] value);
      int           gap;
      rcfd_req_type beat;
      beat.cmd     = cmd;
      beat.rx_byte = value;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_idle();
      send_beat(CMD_IDLE, 8'($urandom));
   endtask

   // Random bytes of a given count, closed by an idle
   task automatic send_burst(input int len);
      repeat (len) send_beat(CMD_DATA, 8'($urandom));
      send_idle();
   endtask

   task automatic send_frame(input logic [FRAME_W-1:0] bits);
      for (int k = 0; k < FRAME_BYTES; k++) send_beat(CMD_DATA, bits[k*8 +: 8]);
      send_idle();
   endtask

   // Hold valid low until every expected frame has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames.pending_count() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic logic [10:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return 11'd0;
         1: return 11'd2047;
         2: return 11'd1024;
         3: return 11'd1023;
         4: return 11'd1025;
         default: return 11'($urandom);
      endcase
   endfunction

   // Frame content: random, with sticks and wheel often at interesting values
   function automatic logic [FRAME_W-1:0] make_frame();
      logic [FRAME_W-1:0] bits;
      int                 pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      for (int k = 0; k < FRAME_W / 16; k++) bits[k*16 +: 16] = 16'($urandom);
      if ($urandom_range(0, 1))
         bits[47:0] = {2'($urandom), 2'($urandom), pick_channel(), pick_channel(),
                       pick_channel(), pick_channel()};
      // wheel near saturation edges and extremes
      case ($urandom_range(0, 11))
         0: bits[143:128] = 16'h7FFF;
         1: bits[143:128] = 16'h8000;
         2: bits[143:128] = 16'h0400;
         3: bits[143:128] = 16'h0000;
         4: bits[143:128] = 16'hFFFF;
         5: bits[143:128] = 16'd2343;
         6: bits[143:128] = 16'd2344;
         7: bits[143:128] = -16'sd296;
         8: bits[143:128] = -16'sd297;
         default: ;
      endcase
      return bits;
   endfunction

   // Request stimulus and end of run
   initial begin : stimulus
      int kind;
      int len;
      int random_beats;
      frames = new();
      req_valid <= 1'b0;
      req_data  <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // Directed: idle with no bytes, all-ones frame, short burst
      send_idle();
      send_frame('1);
      send_burst(3);
      wait_drained();

      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            send_frame(make_frame());
            random_beats += FRAME_BYTES + 1;
         end else if (kind < 89) begin
            len = $urandom_range(1, FRAME_BYTES - 1);
            send_burst(len);
            random_beats += len + 1;
         end else if (kind < 94) begin
            len = $urandom_range(FRAME_BYTES + 1, BUFFER_BYTES - 1);
            send_burst(len);
            random_beats += len + 1;
         end else if (kind < 97) begin
            // long burst, count saturates
            len = $urandom_range(BUFFER_BYTES, 90);
            send_burst(len);
            random_beats += len + 1;
         end else begin
            // stray idles, ignored by the block
            repeat ($urandom_range(1, 3)) send_idle();
         end
         if ($urandom_range(0, 24) == 0) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.error_count() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side: stall patterns plus one long hold-off
   initial begin : receiver
      int mode;
      int span;
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && frames.frames_checked >= 12) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom);
                  2: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

endmodule
